// ===== rtl/core/lacb_pkg.sv =====
// shared types and constants for the look-at camera basis pipeline
`timescale 1ns / 1ps
package lacb_pkg;

   localparam int POS_W  = 32;
   localparam int IN_W   = 33;
   localparam int MAG_W  = 24;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int N2_W   = 50;
   localparam int RAD_W  = 62;
   localparam int ROOT_W = 31;
   localparam int NUM_W  = 46;
   localparam int QB     = 15;
   localparam int Q_W    = 16;
   localparam int SIDE_W = 144;
   localparam int N2_LIM_W = 6;

   localparam logic [Q_W-1:0]        QONE         = 16'd16384;
   localparam logic signed [Q_W-1:0] VERT_POS     = 16'sd16368;
   localparam logic signed [Q_W-1:0] VERT_NEG     = -16'sd16368;
   localparam logic [N2_LIM_W-1:0]   FWD_MIN_N2   = 6'd42;
   localparam logic [N2_LIM_W-1:0]   RIGHT_MIN_N2 = 6'd2;

   typedef struct packed {
      logic                      valid;
      logic [2:0][IN_W-1:0]      c;
      logic [SIDE_W-1:0]         side;
   } lacb_vec_type;

   typedef struct packed {
      logic                      valid;
      logic                      shrt;
      logic [2:0][Q_W-1:0]       u;
      logic [SIDE_W-1:0]         side;
   } lacb_unit_type;

   typedef struct packed {
      logic                      valid;
      logic                      shrt;
      logic [2:0]                neg;
      logic [2:0][MAG_W-1:0]     mag;
      logic [SIDE_W-1:0]         side;
   } lacb_ctl_type;

endpackage

// ===== rtl/core/lacb_norm.sv =====
// vector normalizer: range shift, squares, pipelined square root and division
`timescale 1ns / 1ps
module lacb_norm import lacb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic [N2_LIM_W-1:0] min_n2,
   input  lacb_vec_type        vin,
   output lacb_unit_type       vout
);

   lacb_ctl_type a_ff, a_in;
   logic         a_sz_ff, a_sz_in;

   always_comb begin
      logic [2:0][IN_W-1:0] m33;
      logic [IN_W-1:0]      mx;
      logic [3:0]           s;
      a_in      = '0;
      a_in.valid = vin.valid;
      a_in.side  = vin.side;
      mx = '0;
      for (int i = 0; i < 3; i++) begin
         a_in.neg[i] = vin.c[i][IN_W-1];
         m33[i] = vin.c[i][IN_W-1] ? (~vin.c[i] + 1'b1) : vin.c[i];
         if (m33[i] > mx) mx = m33[i];
      end
      s = '0;
      for (int i = MAG_W; i < IN_W; i++) begin
         if (mx[i]) s = 4'(i - MAG_W + 1);
      end
      for (int i = 0; i < 3; i++) begin
         a_in.mag[i] = MAG_W'(m33[i] >> s);
      end
      a_sz_in = (s == 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else if (en) begin
         a_ff    <= a_in;
         a_sz_ff <= a_sz_in;
      end
   end

   lacb_ctl_type         b_ff;
   logic                 b_sz_ff;
   logic [2:0][SQ_W-1:0] b_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else if (en) begin
         b_ff    <= a_ff;
         b_sz_ff <= a_sz_ff;
         for (int i = 0; i < 3; i++) begin
            b_sq_ff[i] <= a_ff.mag[i] * a_ff.mag[i];
         end
      end
   end

   lacb_ctl_type    c_ff, c_in;
   logic [N2_W-1:0] c_n2_ff, c_n2_in;

   always_comb begin
      c_n2_in = {2'b0, b_sq_ff[0]} + {2'b0, b_sq_ff[1]} + {2'b0, b_sq_ff[2]};
      c_in      = b_ff;
      c_in.shrt = b_sz_ff && (c_n2_in <= {{(N2_W-N2_LIM_W){1'b0}}, min_n2});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid <= 1'b0;
      end else if (en) begin
         c_ff    <= c_in;
         c_n2_ff <= c_n2_in;
      end
   end

   lacb_ctl_type      sr_ctl  [0:ROOT_W];
   logic [RAD_W-1:0]  sr_rem  [0:ROOT_W];
   logic [ROOT_W-1:0] sr_root [0:ROOT_W];

   assign sr_ctl[0]  = c_ff;
   assign sr_rem[0]  = {c_n2_ff, 12'b0};
   assign sr_root[0] = '0;

   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      localparam int K = ROOT_W - 1 - j;
      logic [63:0] t;
      logic        take;
      assign t    = ({33'b0, sr_root[j]} << (K + 1)) | (64'd1 << (2 * K));
      assign take = {2'b0, sr_rem[j]} >= t;
      always_ff @(posedge clock) begin
         if (reset) begin
            sr_ctl[j+1].valid <= 1'b0;
         end else if (en) begin
            sr_ctl[j+1]  <= sr_ctl[j];
            sr_rem[j+1]  <= take ? (sr_rem[j] - t[RAD_W-1:0]) : sr_rem[j];
            sr_root[j+1] <= take ? (sr_root[j] | (ROOT_W'(1) << K)) : sr_root[j];
         end
      end
   end

   lacb_ctl_type          dv_ctl [0:QB];
   logic [2:0][NUM_W-1:0] dv_rem [0:QB];
   logic [2:0][QB-1:0]    dv_q   [0:QB];
   logic [2:0]            dv_sat [0:QB];
   logic [ROOT_W-1:0]     dv_len [0:QB];

   always_ff @(posedge clock) begin
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] lim;
      if (reset) begin
         dv_ctl[0].valid <= 1'b0;
      end else if (en) begin
         lim = {sr_root[ROOT_W], {QB{1'b0}}};
         dv_ctl[0] <= sr_ctl[ROOT_W];
         dv_len[0] <= sr_root[ROOT_W];
         for (int i = 0; i < 3; i++) begin
            num = ({22'b0, sr_ctl[ROOT_W].mag[i]} << 20)
                + {16'b0, sr_root[ROOT_W][ROOT_W-1:1]};
            dv_rem[0][i] <= num;
            dv_sat[0][i] <= (num >= lim);
            dv_q[0][i]   <= '0;
         end
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int K = QB - 1 - j;
      logic [NUM_W-1:0] d;
      assign d = {{QB{1'b0}}, dv_len[j]} << K;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ctl[j+1].valid <= 1'b0;
         end else if (en) begin
            dv_ctl[j+1] <= dv_ctl[j];
            dv_len[j+1] <= dv_len[j];
            dv_sat[j+1] <= dv_sat[j];
            for (int i = 0; i < 3; i++) begin
               if (!dv_sat[j][i] && dv_rem[j][i] >= d) begin
                  dv_rem[j+1][i] <= dv_rem[j][i] - d;
                  dv_q[j+1][i]   <= dv_q[j][i] | (QB'(1) << K);
               end else begin
                  dv_rem[j+1][i] <= dv_rem[j][i];
                  dv_q[j+1][i]   <= dv_q[j][i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [Q_W-1:0] m;
      if (reset) begin
         vout.valid <= 1'b0;
      end else if (en) begin
         vout.valid <= dv_ctl[QB].valid;
         vout.shrt  <= dv_ctl[QB].shrt;
         vout.side  <= dv_ctl[QB].side;
         for (int i = 0; i < 3; i++) begin
            m = {1'b0, dv_q[QB][i]};
            if (dv_sat[QB][i] || m > QONE) m = QONE;
            vout.u[i] <= dv_ctl[QB].neg[i] ? (~m + 1'b1) : m;
         end
      end
   end

endmodule

// ===== rtl/core/lacb_cross.sv =====
// up vector as forward cross right, rounded and saturated to q1.14
`timescale 1ns / 1ps
module lacb_cross import lacb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [2:0][Q_W-1:0]  f,
   input  logic [2:0][Q_W-1:0]  r,
   input  logic [3*POS_W-1:0]   pos,
   output logic                 out_valid,
   output logic [2:0][Q_W-1:0]  r_out,
   output logic [2:0][Q_W-1:0]  u_out,
   output logic [2:0][Q_W-1:0]  f_out,
   output logic [3*POS_W-1:0]   pos_out
);

   logic                       p_valid_ff;
   logic [5:0][2*Q_W-1:0]      p_ff;
   logic [2:0][Q_W-1:0]        p_f_ff, p_r_ff;
   logic [3*POS_W-1:0]         p_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= in_valid;
         p_f_ff     <= f;
         p_r_ff     <= r;
         p_pos_ff   <= pos;
         p_ff[0] <= $signed(f[1]) * $signed(r[2]);
         p_ff[1] <= $signed(f[2]) * $signed(r[1]);
         p_ff[2] <= $signed(f[2]) * $signed(r[0]);
         p_ff[3] <= $signed(f[0]) * $signed(r[2]);
         p_ff[4] <= $signed(f[0]) * $signed(r[1]);
         p_ff[5] <= $signed(f[1]) * $signed(r[0]);
      end
   end

   always_ff @(posedge clock) begin
      logic signed [2*Q_W:0] v;
      logic [2*Q_W:0]        mg;
      logic [2*Q_W:0]        q;
      logic [Q_W-1:0]        m;
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= p_valid_ff;
         r_out     <= p_r_ff;
         f_out     <= p_f_ff;
         pos_out   <= p_pos_ff;
         for (int i = 0; i < 3; i++) begin
            v  = $signed({p_ff[2*i][2*Q_W-1], p_ff[2*i]})
               - $signed({p_ff[2*i+1][2*Q_W-1], p_ff[2*i+1]});
            mg = v[2*Q_W] ? (~v + 1'b1) : v;
            q  = (mg + 33'd8192) >> 14;
            m  = (q > {17'b0, QONE}) ? QONE : q[Q_W-1:0];
            u_out[i] <= v[2*Q_W] ? (~m + 1'b1) : m;
         end
      end
   end

endmodule

// ===== rtl/core/look_at_camera_basis.sv =====
// top level of the look-at camera basis pipeline
`timescale 1ns / 1ps
// Builds a Y-up camera basis from a Q16.16 camera position and look-at point:
// forward, right and up as saturated Q1.14 vectors, plus the position passed
// through. One item is accepted every cycle while the result side does not
// stall. The pipeline is the difference register, a normalizer of 51 stages
// (range shift, squares, sum, a 31-stage square root, divider setup, a
// 15-stage divider and an output register), the right-vector setup register,
// a second such normalizer and the two stages of the cross product. A stall
// on the result side holds the whole pipeline.
module look_at_camera_basis import lacb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, look_x, look_y, look_z
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // right_x/y/z, upv_x/y/z, fwd_x/y/z, out_pos_x/y/z
   output logic [239:0] rsp_tdata
);

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   lacb_vec_type fin_ff, rin_ff;
   lacb_unit_type fo, ro;

   always_ff @(posedge clock) begin
      logic signed [IN_W-1:0] p, l;
      if (reset) begin
         fin_ff.valid <= 1'b0;
      end else if (en) begin
         fin_ff.valid <= req_tvalid;
         fin_ff.side  <= {48'b0, req_tdata[95:0]};
         for (int i = 0; i < 3; i++) begin
            p = $signed({req_tdata[32*i+31], req_tdata[32*i +: 32]});
            l = $signed({req_tdata[32*i+127], req_tdata[32*i+96 +: 32]});
            fin_ff.c[i] <= l - p;
         end
      end
   end

   lacb_norm u_fwd (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .min_n2 (FWD_MIN_N2),
      .vin    (fin_ff),
      .vout   (fo)
   );

   always_ff @(posedge clock) begin
      logic [2:0][Q_W-1:0] f;
      logic [2:0][Q_W-1:0] rc;
      if (reset) begin
         rin_ff.valid <= 1'b0;
      end else if (en) begin
         f = fo.shrt ? {QONE, 16'd0, 16'd0} : fo.u;
         if ($signed(f[1]) >= VERT_POS || $signed(f[1]) <= VERT_NEG) begin
            rc[0] = ~f[1] + 1'b1;
            rc[1] = f[0];
            rc[2] = '0;
         end else begin
            rc[0] = f[2];
            rc[1] = '0;
            rc[2] = ~f[0] + 1'b1;
         end
         rin_ff.valid <= fo.valid;
         rin_ff.side  <= {f, fo.side[95:0]};
         for (int i = 0; i < 3; i++) begin
            rin_ff.c[i] <= {{(IN_W-Q_W){rc[i][Q_W-1]}}, rc[i]};
         end
      end
   end

   lacb_norm u_right (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .min_n2 (RIGHT_MIN_N2),
      .vin    (rin_ff),
      .vout   (ro)
   );

   logic [2:0][Q_W-1:0] r_sel;
   logic [2:0][Q_W-1:0] r_o, u_o, f_o;
   logic [3*POS_W-1:0]  pos_o;

   assign r_sel = ro.shrt ? {16'd0, 16'd0, QONE} : ro.u;

   lacb_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ro.valid),
      .f         (ro.side[143:96]),
      .r         (r_sel),
      .pos       (ro.side[95:0]),
      .out_valid (rsp_tvalid),
      .r_out     (r_o),
      .u_out     (u_o),
      .f_out     (f_o),
      .pos_out   (pos_o)
   );

   assign rsp_tdata = {pos_o, f_o, u_o, r_o};

endmodule
